### rtl/gsa_pkg.sv
package gsa_pkg;

	localparam int SLOTS    = 64;
	localparam int GEN_BITS = 16;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int FAIL_W   = 32;
	localparam int CFG_W    = 16;

	localparam logic [CNT_W-1:0]    LIMIT_RST = CNT_W'(SLOTS);
	localparam logic [GEN_BITS-1:0] SEED_RST  = GEN_BITS'(1);

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CHECK   = 2'd2,
		OP_INIT    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOINIT  = 2'd1,
		ST_BADHNDL = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_SLOT_LIMIT = 1'b0,
		CFG_GEN_SEED   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic                do_init;
		logic                do_alloc;
		logic                do_release;
		logic                chk_en;
		logic [SLOT_W-1:0]   slot;
		logic [GEN_BITS-1:0] gen;
		logic [GEN_BITS-1:0] seed;
		logic [CNT_W-1:0]    limit;
	} cell_ctrl_t;

	typedef struct packed {
		logic                grant;
		logic                hit;
		logic [GEN_BITS-1:0] gen;
	} cell_res_t;

endpackage

### rtl/gsa_cell.sv
module gsa_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [gsa_pkg::SLOT_W-1:0] cell_idx,
	input  gsa_pkg::cell_ctrl_t        ctrl,
	input  logic                       found_in,
	output logic                       found_out,
	output gsa_pkg::cell_res_t         res
);

	logic                         active_q;
	logic                         en_q;
	logic [gsa_pkg::GEN_BITS-1:0] gen_q;
	logic                         free;
	logic                         grant;
	logic                         hit;
	logic [gsa_pkg::GEN_BITS-1:0] gen_fix;

	assign free      = en_q & ~active_q;
	assign grant     = free & ~found_in;
	assign found_out = found_in | free;
	assign hit       = ctrl.chk_en & en_q & active_q & (ctrl.slot == cell_idx)
		& (gen_q == ctrl.gen);
	assign gen_fix   = (gen_q == '0) ? gsa_pkg::GEN_BITS'(1) : gen_q;

	assign res.grant = grant;
	assign res.hit   = hit;
	assign res.gen   = grant ? gen_fix : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			en_q     <= 1'b0;
			gen_q    <= '0;
		end else if (ctrl.do_init) begin
			active_q <= 1'b0;
			en_q     <= ({1'b0, cell_idx} < ctrl.limit);
			gen_q    <= ctrl.seed;
		end else if (ctrl.do_alloc && grant) begin
			active_q <= 1'b1;
			gen_q    <= gen_fix;
		end else if (ctrl.do_release && hit) begin
			active_q <= 1'b0;
			gen_q    <= gen_q + gsa_pkg::GEN_BITS'(1);
		end
	end

endmodule

### rtl/generational_slot_allocator_core.sv
// The accepted start beat is registered into valid_s1, then into done_q, which drives the done strobe.
// A new operation cannot be accepted while busy; busy is high for the cycle after accept.
// The lowest-free-slot search ripples down the slot cell chain while the operation is in the s1 registers.
// Results are shown for one cycle with done; the receiver cannot stall.
// Reset (arst_n low): not initialized, all slots inactive at generation zero,
// counters zero, slot_limit 64, generation_seed 1.
module generational_slot_allocator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   opcode,
	input  logic [gsa_pkg::SLOT_W-1:0]   slot_index,
	input  logic [gsa_pkg::GEN_BITS-1:0] handle_generation,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [gsa_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                         done,
	output logic [1:0]                   status,
	output logic                         handle_valid,
	output logic [gsa_pkg::SLOT_W-1:0]   out_slot,
	output logic [gsa_pkg::GEN_BITS-1:0] out_generation,
	output logic [gsa_pkg::CNT_W-1:0]    active_count,
	output logic [gsa_pkg::FAIL_W-1:0]   failure_count
);

	logic [gsa_pkg::CNT_W-1:0]    limit_q;
	logic [gsa_pkg::GEN_BITS-1:0] seed_q;
	logic                         ready_q;
	logic [gsa_pkg::CNT_W-1:0]    live_q;
	logic [gsa_pkg::FAIL_W-1:0]   fail_q;

	logic                         valid_s1;
	gsa_pkg::opcode_t             op_s1;
	logic [gsa_pkg::SLOT_W-1:0]   slot_s1;
	logic [gsa_pkg::GEN_BITS-1:0] hgen_s1;

	logic                         done_q;
	gsa_pkg::status_t             status_q;
	logic                         valid_q;
	logic [gsa_pkg::SLOT_W-1:0]   oslot_q;
	logic [gsa_pkg::GEN_BITS-1:0] ogen_q;

	gsa_pkg::cell_ctrl_t          ctrl;
	gsa_pkg::cell_res_t           res [gsa_pkg::SLOTS];
	logic [gsa_pkg::SLOTS:0]      found;

	logic                         any_grant;
	logic                         any_hit;
	logic [gsa_pkg::SLOT_W-1:0]   gslot;
	logic [gsa_pkg::GEN_BITS-1:0] ggen;
	logic [gsa_pkg::CNT_W-1:0]    clamp_limit;
	logic                         hnd_ok;
	logic                         fail;
	gsa_pkg::status_t             status_d;
	logic                         valid_d;
	logic [gsa_pkg::CNT_W-1:0]    live_d;
	logic                         accept_beat;

	assign accept_beat = start & ~busy;

	assign busy = valid_s1;

	assign clamp_limit = (limit_q > gsa_pkg::CNT_W'(gsa_pkg::SLOTS))
		? gsa_pkg::CNT_W'(gsa_pkg::SLOTS) : limit_q;

	always_comb begin
		ctrl            = '0;
		ctrl.do_init    = valid_s1 && (op_s1 == gsa_pkg::OP_INIT);
		ctrl.do_alloc   = valid_s1 && (op_s1 == gsa_pkg::OP_ALLOC) && ready_q;
		ctrl.do_release = valid_s1 && (op_s1 == gsa_pkg::OP_RELEASE);
		ctrl.chk_en     = ready_q && (hgen_s1 != '0);
		ctrl.slot       = slot_s1;
		ctrl.gen        = hgen_s1;
		ctrl.seed       = seed_q;
		ctrl.limit      = clamp_limit;
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < gsa_pkg::SLOTS; i++) begin : g_cell
		gsa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (gsa_pkg::SLOT_W'(i)),
			.ctrl      (ctrl),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.res       (res[i])
		);
	end

	always_comb begin
		any_hit = 1'b0;
		gslot   = '0;
		ggen    = '0;
		for (int i = 0; i < gsa_pkg::SLOTS; i++) begin
			any_hit = any_hit | res[i].hit;
			gslot   = gslot | (res[i].grant ? gsa_pkg::SLOT_W'(i) : '0);
			ggen    = ggen | res[i].gen;
		end
	end

	assign any_grant = found[gsa_pkg::SLOTS];
	assign hnd_ok    = ready_q && (hgen_s1 != '0) && any_hit;

	always_comb begin
		status_d = gsa_pkg::ST_OK;
		valid_d  = 1'b0;
		fail     = 1'b0;
		live_d   = live_q;
		case (op_s1)
			gsa_pkg::OP_ALLOC: begin
				if (!ready_q) begin
					status_d = gsa_pkg::ST_NOINIT;
					fail     = 1'b1;
				end else if (any_grant) begin
					live_d = live_q + gsa_pkg::CNT_W'(1);
				end else begin
					status_d = gsa_pkg::ST_FULL;
					fail     = 1'b1;
				end
			end
			gsa_pkg::OP_RELEASE: begin
				if (!hnd_ok) begin
					status_d = gsa_pkg::ST_BADHNDL;
					fail     = 1'b1;
				end else if (live_q != '0) begin
					live_d = live_q - gsa_pkg::CNT_W'(1);
				end
			end
			gsa_pkg::OP_CHECK: begin
				if (!ready_q) begin
					status_d = gsa_pkg::ST_NOINIT;
				end else if (hnd_ok) begin
					valid_d = 1'b1;
				end else begin
					status_d = gsa_pkg::ST_BADHNDL;
				end
			end
			gsa_pkg::OP_INIT: begin
				live_d = '0;
			end
			default: begin
				status_d = gsa_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gsa_pkg::LIMIT_RST;
			seed_q  <= gsa_pkg::SEED_RST;
		end else if (cfg_we) begin
			case (gsa_pkg::cfg_idx_t'(cfg_index))
				gsa_pkg::CFG_SLOT_LIMIT: limit_q <= cfg_wdata[gsa_pkg::CNT_W-1:0];
				gsa_pkg::CFG_GEN_SEED:   seed_q  <= cfg_wdata[gsa_pkg::GEN_BITS-1:0];
				default:                 seed_q  <= seed_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_beat) begin
			op_s1   <= gsa_pkg::opcode_t'(opcode);
			slot_s1 <= slot_index;
			hgen_s1 <= handle_generation;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			live_q  <= '0;
			fail_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				live_q <= live_d;
				if (op_s1 == gsa_pkg::OP_INIT) begin
					ready_q <= 1'b1;
					fail_q  <= '0;
				end else if (fail && (fail_q != '1)) begin
					fail_q <= fail_q + gsa_pkg::FAIL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= status_d;
			valid_q  <= valid_d;
			oslot_q  <= (ctrl.do_alloc && any_grant) ? gslot : '0;
			ogen_q   <= (ctrl.do_alloc && any_grant) ? ggen : '0;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign handle_valid   = valid_q;
	assign out_slot       = oslot_q;
	assign out_generation = ogen_q;
	assign active_count   = live_q;
	assign failure_count  = fail_q;

endmodule

### rtl/gsa_checker.sv
module gsa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [1:0]                   status,
	input logic                         handle_valid,
	input logic [gsa_pkg::SLOT_W-1:0]   out_slot,
	input logic [gsa_pkg::GEN_BITS-1:0] out_generation
);

	a_done_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("done without an accepted beat two cycles earlier");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 (!busy && done))
		else $error("busy/done sequence broken after accept");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && handle_valid) |-> (status == gsa_pkg::ST_OK))
		else $error("handle_valid with failing status");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != gsa_pkg::ST_OK)) |-> (out_slot == '0 && out_generation == '0))
		else $error("grant fields set on failed operation");

endmodule

bind generational_slot_allocator_core gsa_checker u_gsa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.handle_valid   (handle_valid),
	.out_slot       (out_slot),
	.out_generation (out_generation)
);
